// File: rtl/sbrp_pkg.sv
// ----------------------------------------------------------------------------
// STUN binding request parser package
// Shared types, protocol constants and the CRC-32 byte step.
// ----------------------------------------------------------------------------
`default_nettype none

package sbrp_pkg;

  localparam logic [31:0] CRC_POLY = 32'hedb88320;
  localparam logic [31:0] FP_XOR = 32'h5354554e;
  localparam logic [15:0] TYPE_BINDING_REQ = 16'h0001;
  localparam logic [15:0] ATTR_USERNAME = 16'h0006;
  localparam logic [15:0] ATTR_INTEGRITY = 16'h0008;
  localparam logic [15:0] ATTR_FINGERPRINT = 16'h8028;
  localparam logic [7:0] TYPE_TOP_MASK = 8'hc0;
  localparam logic [16:0] COUNT_MAX = 17'h1ffff;
  localparam logic [16:0] HEADER_BYTES = 17'd20;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_SUM,
    ST_CRC
  } eng_state_t;

  typedef struct packed {
    logic        data_valid;
    logic [7:0]  data_byte;
    logic        end_of_packet;
  } queue_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  user_byte;
    logic        user_restart;
    logic        status;
    logic [7:0]  user_length;
    logic        has_integrity;
    logic        fp_seen;
    logic        fingerprint_ok;
    logic [31:0] txid_high;
    logic [63:0] txid_low;
    logic        last;
  } result_t;

  function automatic logic [7:0] cookie_byte(input logic [1:0] sel);
    logic [7:0] val;
    unique case (sel)
      2'd0: val = 8'h21;
      2'd1: val = 8'h12;
      2'd2: val = 8'ha4;
      default: val = 8'h42;
    endcase
    return val;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/stun_binding_request_parser_core.sv
// ----------------------------------------------------------------------------
// STUN binding request parser core
// Parses a received STUN packet byte by byte and reports username and summary.
// ----------------------------------------------------------------------------
// Usage: packet bytes enter on the input channel (in_valid, in_stall) with
// end_of_packet high on the final byte. Each username byte kept yields one
// result item of kind 0; the final byte yields a summary item of kind 1 with
// last high.
// An item passes a four-entry input queue and the parse engine: a byte is
// written into the queue, and its result is loaded into the output register
// when the engine takes the byte from the queue head. Bytes are taken at one
// per cycle while the output is free and no CRC walk or held summary waits;
// a final byte that also carries a username byte emits both results in turn.
// A fingerprint attribute starts a CRC-32 walk over the stored prefix, one
// stored byte per cycle through the store's read port, and the engine takes
// no bytes until the walk ends; the input queue keeps filling meanwhile.
// Reset clears the queue, the output valid flag and all per-packet state.
// When the receiver stalls, the output item holds and the engine stops
// taking bytes; the input stalls once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module stun_binding_request_parser_core #(
  parameter int STORE_BYTES = 2048,
  parameter int USER_MAX = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_packet,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             kind,
  output logic [7:0]       user_byte,
  output logic             user_restart,
  output logic             status,
  output logic [7:0]       user_length,
  output logic             has_integrity,
  output logic             fp_seen,
  output logic             fingerprint_ok,
  output logic [31:0]      txid_high,
  output logic [63:0]      txid_low,
  output logic             last
);

  sbrp_pkg::queue_item_t head;
  sbrp_pkg::result_t res;
  logic pop;

  sbrp_queue u_queue (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .end_of_packet (end_of_packet),
    .head          (head),
    .pop           (pop)
  );

  sbrp_engine #(
    .STORE_BYTES (STORE_BYTES),
    .USER_MAX    (USER_MAX)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign kind = res.kind;
  assign user_byte = res.user_byte;
  assign user_restart = res.user_restart;
  assign status = res.status;
  assign user_length = res.user_length;
  assign has_integrity = res.has_integrity;
  assign fp_seen = res.fp_seen;
  assign fingerprint_ok = res.fingerprint_ok;
  assign txid_high = res.txid_high;
  assign txid_low = res.txid_low;
  assign last = res.last;

endmodule

`default_nettype wire

// File: rtl/sbrp_queue.sv
// ----------------------------------------------------------------------------
// STUN parser input queue
// Accepts packet bytes and holds them for the parse engine.
// ----------------------------------------------------------------------------
`default_nettype none

module sbrp_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         data_byte,
  input  wire logic               end_of_packet,
  output sbrp_pkg::queue_item_t   head,
  input  wire logic               pop
);

  logic [8:0] slots [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       push;
  logic       take;

  assign in_stall = (count == 3'd4);
  assign push = in_valid && !in_stall;
  assign take = pop && (count != 3'd0);

  assign head.data_valid = (count != 3'd0);
  assign head.data_byte = slots[rd_ptr][7:0];
  assign head.end_of_packet = slots[rd_ptr][8];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= {end_of_packet, data_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {2'b0, push} - {2'b0, take};
    end
  end

endmodule

`default_nettype wire

// File: rtl/sbrp_engine.sv
// ----------------------------------------------------------------------------
// STUN parser engine
// Stores the packet, walks the header and attributes, checks the fingerprint.
// ----------------------------------------------------------------------------
`default_nettype none

module sbrp_engine #(
  parameter int STORE_BYTES = 2048,
  parameter int USER_MAX = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  sbrp_pkg::queue_item_t  head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output sbrp_pkg::result_t      out_res
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam logic [17:0] STORE_LIM = 18'(STORE_BYTES);
  localparam logic [16:0] UCAP = 17'(USER_MAX - 1);

  logic [7:0] store [STORE_BYTES];
  logic [7:0] rd_data;

  sbrp_pkg::eng_state_t state, state_next;

  logic [16:0] byte_count, bc_next;
  logic [16:0] msg_limit, me_next;
  logic [16:0] attr_offset, ao_next;
  logic [15:0] attr_type_reg, at_next;
  logic [15:0] attr_len_reg, al_next;
  logic [7:0]  user_count, uc_next;
  logic        user_first_zero, ufz_next;
  logic [31:0] fp_received, fpr_next;
  logic [31:0] crc_reg;
  logic        err, err_next;
  logic        has_mi, mi_next;
  logic        has_fp, fp_next;
  logic        fp_ok, fpok_next;
  logic [31:0] txid_high, txh_next;
  logic [63:0] txid_low, txl_next;
  logic [7:0]  byte0, b0_next;
  logic [7:0]  byte2, b2_next;

  logic [16:0] crc_addr;
  logic [16:0] rd_idx;
  logic        rd_v;
  logic [31:0] crc_acc;
  logic [31:0] crc_step;
  logic [15:0] fake_len;
  logic [7:0]  crc_in_byte;
  logic        crc_done;

  logic        out_free;
  logic        take;
  logic        load_sum;
  logic        start_crc;
  logic        emit_user;
  logic        eop;
  logic [7:0]  b;
  logic [16:0] p;
  logic [16:0] rel;
  logic [16:0] idx;
  logic [15:0] hlen;
  logic [16:0] pad;
  logic [16:0] body_pad;
  logic [17:0] vo_pad;
  logic [16:0] cap;
  logic        bad;
  sbrp_pkg::result_t user_res;
  sbrp_pkg::result_t sum_res;
  sbrp_pkg::result_t pend;

  assign out_free = !out_valid || !out_stall;
  assign b = head.data_byte;
  assign eop = head.end_of_packet;
  assign p = byte_count;
  assign rel = p - attr_offset;
  assign idx = rel - 17'd4;
  assign body_pad = ({1'b0, attr_len_reg} + 17'd3) & ~17'd3;

  always_comb begin
    bc_next = (byte_count != sbrp_pkg::COUNT_MAX) ? byte_count + 17'd1 : byte_count;
    me_next = msg_limit;
    ao_next = attr_offset;
    at_next = attr_type_reg;
    al_next = attr_len_reg;
    uc_next = user_count;
    ufz_next = user_first_zero;
    fpr_next = fp_received;
    err_next = err;
    mi_next = has_mi;
    fp_next = has_fp;
    fpok_next = fp_ok;
    txh_next = txid_high;
    txl_next = txid_low;
    b0_next = byte0;
    b2_next = byte2;
    start_crc = 1'b0;
    emit_user = 1'b0;
    hlen = '0;
    pad = '0;
    vo_pad = '0;
    cap = '0;
    if (p < sbrp_pkg::HEADER_BYTES) begin
      if (p == 17'd0) begin
        b0_next = b;
      end else if (p == 17'd1) begin
        if ((byte0 & sbrp_pkg::TYPE_TOP_MASK) != 8'h0 ||
            {byte0, b} != sbrp_pkg::TYPE_BINDING_REQ) begin
          err_next = 1'b1;
        end
      end else if (p == 17'd2) begin
        b2_next = b;
      end else if (p == 17'd3) begin
        if (b[1:0] != 2'b0) begin
          err_next = 1'b1;
        end
        me_next = sbrp_pkg::HEADER_BYTES + {1'b0, byte2, b};
      end else if (p < 17'd8) begin
        if (b != sbrp_pkg::cookie_byte(p[1:0])) begin
          err_next = 1'b1;
        end
      end else if (p < 17'd12) begin
        txh_next = {txid_high[23:0], b};
      end else begin
        txl_next = {txid_low[55:0], b};
      end
    end else if (!err && p < msg_limit && p >= attr_offset) begin
      if (rel == 17'd0) begin
        at_next = {b, 8'h0};
      end else if (rel == 17'd1) begin
        at_next = {attr_type_reg[15:8], b};
      end else if (rel == 17'd2) begin
        al_next = {b, 8'h0};
      end else if (rel == 17'd3) begin
        hlen = {attr_len_reg[15:8], b};
        al_next = hlen;
        pad = ({1'b0, hlen} + 17'd3) & ~17'd3;
        vo_pad = {1'b0, attr_offset} + 18'd4 + {1'b0, pad};
        if (vo_pad > {1'b0, msg_limit}) begin
          err_next = 1'b1;
        end else begin
          if (attr_type_reg == sbrp_pkg::ATTR_USERNAME) begin
            uc_next = '0;
            ufz_next = 1'b1;
          end else if (attr_type_reg == sbrp_pkg::ATTR_INTEGRITY) begin
            mi_next = 1'b1;
            if (hlen != 16'd20 || {1'b0, attr_offset} > STORE_LIM) begin
              err_next = 1'b1;
            end
          end else if (attr_type_reg == sbrp_pkg::ATTR_FINGERPRINT) begin
            fp_next = 1'b1;
            if (hlen != 16'd4 || {1'b0, attr_offset} > STORE_LIM) begin
              err_next = 1'b1;
            end else begin
              start_crc = 1'b1;
              fpr_next = '0;
            end
          end
          if (pad == 17'd0 && !err_next) begin
            ao_next = attr_offset + 17'd4;
          end
        end
      end else begin
        cap = ({1'b0, attr_len_reg} < UCAP) ? {1'b0, attr_len_reg} : UCAP;
        if (attr_type_reg == sbrp_pkg::ATTR_USERNAME) begin
          if (idx < cap) begin
            if (idx == 17'd0) begin
              ufz_next = (b == 8'h0);
            end
            uc_next = 8'(idx + 17'd1);
            emit_user = 1'b1;
          end
        end else if (attr_type_reg == sbrp_pkg::ATTR_FINGERPRINT && idx < 17'd4) begin
          fpr_next = {fp_received[23:0], b};
          if (idx == 17'd3) begin
            fpok_next = (fpr_next == crc_reg);
          end
        end
        if ({1'b0, idx} + 18'd1 >= {1'b0, body_pad}) begin
          ao_next = attr_offset + 17'd4 + body_pad;
        end
      end
    end
  end

  always_comb begin
    bad = err_next || bc_next < sbrp_pkg::HEADER_BYTES || bc_next < me_next ||
          ufz_next;
    user_res = '0;
    user_res.user_byte = b;
    user_res.user_restart = (idx == 17'd0);
    sum_res = '0;
    sum_res.kind = 1'b1;
    sum_res.status = bad;
    sum_res.user_length = uc_next;
    sum_res.has_integrity = mi_next;
    sum_res.fp_seen = fp_next;
    sum_res.fingerprint_ok = fpok_next;
    sum_res.txid_high = txh_next;
    sum_res.txid_low = txl_next;
    sum_res.last = 1'b1;
  end

  assign fake_len = 16'(attr_offset - 17'd12);
  always_comb begin
    crc_in_byte = rd_data;
    if (rd_idx == 17'd2) begin
      crc_in_byte = fake_len[15:8];
    end else if (rd_idx == 17'd3) begin
      crc_in_byte = fake_len[7:0];
    end
  end
  assign crc_step = sbrp_pkg::crc_byte(crc_acc, crc_in_byte);
  assign crc_done = rd_v && (rd_idx == attr_offset - 17'd1);

  always_comb begin
    state_next = state;
    unique case (state)
      sbrp_pkg::ST_RUN: begin
        if (take && emit_user && eop) begin
          state_next = sbrp_pkg::ST_SUM;
        end else if (take && start_crc && !eop) begin
          state_next = sbrp_pkg::ST_CRC;
        end
      end
      sbrp_pkg::ST_SUM: begin
        if (out_free) begin
          state_next = sbrp_pkg::ST_RUN;
        end
      end
      sbrp_pkg::ST_CRC: begin
        if (crc_done) begin
          state_next = sbrp_pkg::ST_RUN;
        end
      end
      default: state_next = sbrp_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    take = 1'b0;
    load_sum = 1'b0;
    unique case (state)
      sbrp_pkg::ST_RUN: take = head.data_valid && out_free;
      sbrp_pkg::ST_SUM: load_sum = out_free;
      sbrp_pkg::ST_CRC: take = 1'b0;
      default: take = 1'b0;
    endcase
  end

  assign pop = take;

  always_ff @(posedge clk) begin
    if (take && {1'b0, p} < STORE_LIM) begin
      store[p[AW-1:0]] <= b;
    end
    rd_data <= store[crc_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (take && emit_user && eop) begin
      pend <= sum_res;
    end
    if (take && (emit_user || eop)) begin
      out_res <= emit_user ? user_res : sum_res;
    end else if (load_sum) begin
      out_res <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbrp_pkg::ST_RUN;
      out_valid <= 1'b0;
      rd_v <= 1'b0;
      crc_addr <= '0;
      rd_idx <= '0;
      crc_acc <= '1;
    end else begin
      state <= state_next;
      if (take && (emit_user || eop)) begin
        out_valid <= 1'b1;
      end else if (load_sum) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (take && start_crc) begin
        crc_addr <= '0;
        rd_v <= 1'b0;
        crc_acc <= '1;
      end else if (state == sbrp_pkg::ST_CRC) begin
        rd_v <= (crc_addr < attr_offset);
        rd_idx <= crc_addr;
        if (crc_addr < attr_offset) begin
          crc_addr <= crc_addr + 17'd1;
        end
        if (rd_v) begin
          crc_acc <= crc_step;
        end
      end else begin
        rd_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && eop)) begin
      byte_count <= '0;
      msg_limit <= '0;
      attr_offset <= sbrp_pkg::HEADER_BYTES;
      attr_type_reg <= '0;
      attr_len_reg <= '0;
      user_count <= '0;
      user_first_zero <= 1'b1;
      fp_received <= '0;
      crc_reg <= '1;
      err <= 1'b0;
      has_mi <= 1'b0;
      has_fp <= 1'b0;
      fp_ok <= 1'b0;
      txid_high <= '0;
      txid_low <= '0;
      byte0 <= '0;
      byte2 <= '0;
    end else if (take) begin
      byte_count <= bc_next;
      msg_limit <= me_next;
      attr_offset <= ao_next;
      attr_type_reg <= at_next;
      attr_len_reg <= al_next;
      user_count <= uc_next;
      user_first_zero <= ufz_next;
      fp_received <= fpr_next;
      err <= err_next;
      has_mi <= mi_next;
      has_fp <= fp_next;
      fp_ok <= fpok_next;
      txid_high <= txh_next;
      txid_low <= txl_next;
      byte0 <= b0_next;
      byte2 <= b2_next;
    end else if (crc_done) begin
      crc_reg <= ~crc_step ^ sbrp_pkg::FP_XOR;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sbrp_checker.sv
// ----------------------------------------------------------------------------
// STUN parser port checker
// Watches the top level's result channel for consistent items.
// ----------------------------------------------------------------------------
`default_nettype none

module sbrp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        kind,
  input wire logic        user_restart,
  input wire logic        status,
  input wire logic [31:0] txid_high,
  input wire logic        last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  a_sum_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> last && !user_restart)
    else $error("summary item without last");

  a_user_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> !last && !status && txid_high == 32'h0)
    else $error("username item carries summary fields");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable({kind, user_restart, status, txid_high, last}))
    else $error("result item changed while stalled");

endmodule

bind stun_binding_request_parser_core sbrp_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .kind         (kind),
  .user_restart (user_restart),
  .status       (status),
  .txid_high    (txid_high),
  .last         (last)
);

`default_nettype wire

// File: test/tb_stun_binding_request_parser_core.sv
// ----------------------------------------------------------------------------
// STUN binding request parser core testbench
// Feeds the parser with well-formed binding requests that carry random
// usernames, integrity and fingerprint attributes, plus damaged packets and
// noise. Each result item is checked against a parser model kept here.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_stun_binding_request_parser_core;

  localparam int STORE_BYTES = 2048;
  localparam int USER_MAX = 256;

  typedef struct {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } byte_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] data_byte = '0;
  logic end_of_packet = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic kind, user_restart, status, has_integrity, fp_seen, fingerprint_ok, last;
  logic [7:0] user_byte, user_length;
  logic [31:0] txid_high;
  logic [63:0] txid_low;

  stun_binding_request_parser_core u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .end_of_packet(end_of_packet), .out_valid(out_valid),
    .out_stall(out_stall), .kind(kind), .user_byte(user_byte),
    .user_restart(user_restart), .status(status), .user_length(user_length),
    .has_integrity(has_integrity), .fp_seen(fp_seen),
    .fingerprint_ok(fingerprint_ok), .txid_high(txid_high), .txid_low(txid_low),
    .last(last)
  );

  always #5 clk = ~clk;

  byte_item_t pending_bytes[$];
  sbrp_pkg::result_t expected_results[$];
  int errors = 0;
  int packets_sent = 0;
  int results_seen = 0;

  // Parser model state.
  logic [7:0] m_store[STORE_BYTES];
  int unsigned m_count, m_end, m_attr_off, m_user_count;
  logic [15:0] m_type, m_len;
  bit m_first_zero, m_err, m_mi, m_fp, m_fpok;
  logic [31:0] m_fp_rx, m_crc;
  logic [31:0] m_txid_high;
  logic [63:0] m_txid_low;

  function automatic logic [7:0] cookie_at(int i);
    logic [7:0] c[4] = '{8'h21, 8'h12, 8'ha4, 8'h42};
    return c[i];
  endfunction

  function automatic void clear_packet_model();
    m_count = 0; m_end = 0; m_attr_off = 20; m_type = 0; m_len = 0;
    m_user_count = 0; m_first_zero = 1; m_fp_rx = 0; m_crc = '1;
    m_err = 0; m_mi = 0; m_fp = 0; m_fpok = 0; m_txid_high = 0; m_txid_low = 0;
  endfunction

  function automatic logic [31:0] fingerprint_over(int unsigned upto);
    logic [31:0] crc;
    logic [15:0] fake_len;
    logic [7:0] b;
    crc = '1;
    fake_len = 16'(upto + 8 - 20);
    for (int unsigned i = 0; i < upto && i < STORE_BYTES; i++) begin
      b = m_store[i];
      if (i == 2) b = fake_len[15:8];
      if (i == 3) b = fake_len[7:0];
      crc ^= {24'h0, b};
      for (int k = 0; k < 8; k++) crc = (crc >> 1) ^ (32'hedb88320 & {32{crc[0]}});
    end
    return ~crc ^ 32'h5354554e;
  endfunction

  function automatic void attr_header_model();
    int unsigned vo, pad;
    vo = m_attr_off + 4;
    pad = (int'(m_len) + 3) & ~3;
    if (vo + pad > m_end) begin
      m_err = 1;
      return;
    end
    if (m_type == sbrp_pkg::ATTR_USERNAME) begin
      m_user_count = 0;
      m_first_zero = 1;
    end else if (m_type == sbrp_pkg::ATTR_INTEGRITY) begin
      m_mi = 1;
      if (m_len != 20 || m_attr_off > STORE_BYTES) begin
        m_err = 1;
        return;
      end
    end else if (m_type == sbrp_pkg::ATTR_FINGERPRINT) begin
      m_fp = 1;
      if (m_len != 4 || m_attr_off > STORE_BYTES) begin
        m_err = 1;
        return;
      end
      m_crc = fingerprint_over(m_attr_off);
      m_fp_rx = 0;
    end
    if (pad == 0) m_attr_off = vo;
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic eop);
    int unsigned p, rel, idx, pad, cap;
    sbrp_pkg::result_t r;
    p = m_count;
    if (p < STORE_BYTES) m_store[p] = b;
    if (m_count < 17'h1ffff) m_count++;
    if (p < 20) begin
      if (p == 1) begin
        if ((m_store[0] & 8'hc0) != 0 || {m_store[0], b} != sbrp_pkg::TYPE_BINDING_REQ)
          m_err = 1;
      end else if (p == 3) begin
        if (b[1:0] != 0) m_err = 1;
        m_end = 20 + {m_store[2], b};
      end else if (p >= 4 && p < 8) begin
        if (b != cookie_at(p - 4)) m_err = 1;
      end else if (p >= 8 && p < 12) begin
        m_txid_high = {m_txid_high[23:0], b};
      end else if (p >= 12) begin
        m_txid_low = {m_txid_low[55:0], b};
      end
    end else if (!m_err && p < m_end && p >= m_attr_off) begin
      rel = p - m_attr_off;
      if (rel == 0) m_type = {b, 8'h0};
      else if (rel == 1) m_type[7:0] = b;
      else if (rel == 2) m_len = {b, 8'h0};
      else if (rel == 3) begin
        m_len[7:0] = b;
        attr_header_model();
      end else begin
        idx = rel - 4;
        pad = (int'(m_len) + 3) & ~3;
        if (m_type == sbrp_pkg::ATTR_USERNAME) begin
          cap = m_len < USER_MAX - 1 ? m_len : USER_MAX - 1;
          if (idx < cap) begin
            if (idx == 0) m_first_zero = (b == 0);
            m_user_count = idx + 1;
            r = '0;
            r.user_byte = b;
            r.user_restart = (idx == 0);
            expected_results.push_back(r);
          end
        end else if (m_type == sbrp_pkg::ATTR_FINGERPRINT && idx < 4) begin
          m_fp_rx = {m_fp_rx[23:0], b};
          if (idx == 3) m_fpok = (m_fp_rx == m_crc);
        end
        if (idx + 1 >= pad) m_attr_off = m_attr_off + 4 + pad;
      end
    end
    if (eop) begin
      r = '0;
      r.kind = 1;
      r.status = m_err || m_count < 20 || m_count < m_end || m_first_zero;
      r.user_length = m_user_count[7:0];
      r.has_integrity = m_mi;
      r.fp_seen = m_fp;
      r.fingerprint_ok = m_fpok;
      r.txid_high = m_txid_high;
      r.txid_low = m_txid_low;
      r.last = 1;
      expected_results.push_back(r);
      clear_packet_model();
    end
  endfunction

  // Packet builder.
  logic [7:0] pkt[$];

  function automatic void put16(int v);
    pkt.push_back(8'(v >> 8));
    pkt.push_back(8'(v));
  endfunction

  function automatic void put_attr(int typ, int len, bit zero_first);
    put16(typ);
    put16(len);
    for (int i = 0; i < len; i++)
      pkt.push_back((i == 0 && zero_first) ? 8'h00 : 8'($urandom_range(1, 255)));
    for (int i = len; i % 4 != 0; i++) pkt.push_back(8'($urandom));
  endfunction

  // Writes a fingerprint attribute at the end of pkt, with one bit flipped when corrupt is set.
  function automatic void put_fingerprint(bit corrupt);
    logic [31:0] crc;
    logic [15:0] fake_len;
    logic [7:0] b;
    int unsigned upto;
    upto = pkt.size();
    fake_len = 16'(upto + 8 - 20);
    crc = '1;
    for (int unsigned i = 0; i < upto; i++) begin
      b = pkt[i];
      if (i == 2) b = fake_len[15:8];
      if (i == 3) b = fake_len[7:0];
      crc = sbrp_pkg::crc_byte(crc, b);
    end
    crc = ~crc ^ sbrp_pkg::FP_XOR;
    if (corrupt) crc[$urandom_range(0, 31)] ^= 1'b1;
    put16(sbrp_pkg::ATTR_FINGERPRINT);
    put16(4);
    put16(crc[31:16]);
    put16(crc[15:0]);
  endfunction

  // Builds one packet; shape picks the style of packet.
  function automatic void build_packet(int shape, int user_len);
    int mlen;
    pkt.delete();
    put16(sbrp_pkg::TYPE_BINDING_REQ);
    put16(0);
    for (int i = 0; i < 4; i++) pkt.push_back(cookie_at(i));
    for (int i = 0; i < 12; i++) pkt.push_back(8'($urandom));
    if ($urandom_range(0, 3) == 0)
      put_attr(16'($urandom_range(0, 65535)) & 16'h7ff0, $urandom_range(0, 9), 0);
    put_attr(sbrp_pkg::ATTR_USERNAME, user_len, shape == 3);
    if ($urandom_range(0, 2) == 0)
      put_attr(sbrp_pkg::ATTR_USERNAME, $urandom_range(1, 12), 0);
    if (shape == 1 || $urandom_range(0, 1))
      put_attr(sbrp_pkg::ATTR_INTEGRITY, (shape == 4) ? 16 : 20, 0);
    mlen = pkt.size() + ($urandom_range(0, 1) ? 8 : 0) - 20;
    pkt[2] = 8'(mlen >> 8);
    pkt[3] = 8'(mlen);
    if (pkt.size() - 20 < mlen) put_fingerprint(shape == 5);
    case (shape)
      6: pkt[$urandom_range(0, 7)] ^= 8'(1 << $urandom_range(0, 7));
      7: pkt[3] = pkt[3] + 8'($urandom_range(1, 3));
      8: pkt = pkt[0:$urandom_range(0, pkt.size() - 2)];
      9: for (int i = 0; i < pkt.size(); i++)
           if (i != 0 && $urandom_range(0, 7) == 0) pkt[i] = 8'($urandom);
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom));
  endfunction

  function automatic void queue_packet();
    byte_item_t it;
    foreach (pkt[i]) begin
      it.data_byte = pkt[i];
      it.end_of_packet = (i == pkt.size() - 1);
      pending_bytes.push_back(it);
    end
    packets_sent++;
  endfunction

  // Driver.
  bit idle_free;
  always @(posedge clk) begin
    if (!rst) begin
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() > 0 && (idle_free || $urandom_range(0, 99) >= 36)) begin
          in_valid <= 1'b1;
          data_byte <= pending_bytes[0].data_byte;
          end_of_packet <= pending_bytes[0].end_of_packet;
          parse_byte(pending_bytes[0].data_byte, pending_bytes[0].end_of_packet);
          void'(pending_bytes.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor.
  sbrp_pkg::result_t got, want;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = '{kind, user_byte, user_restart, status, user_length, has_integrity,
                fp_seen, fingerprint_ok, txid_high, txid_low, last};
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result item, exp none got %h", $time, got);
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind) begin
            errors++;
            $display("%0t: kind exp %h got %h", $time, want.kind, got.kind);
          end
          if (got.user_byte !== want.user_byte) begin
            errors++;
            $display("%0t: user_byte exp %h got %h", $time, want.user_byte, got.user_byte);
          end
          if (got.user_restart !== want.user_restart) begin
            errors++;
            $display("%0t: user_restart exp %h got %h", $time, want.user_restart,
                     got.user_restart);
          end
          if (got.status !== want.status) begin
            errors++;
            $display("%0t: status exp %h got %h", $time, want.status, got.status);
          end
          if (got.user_length !== want.user_length) begin
            errors++;
            $display("%0t: user_length exp %h got %h", $time, want.user_length,
                     got.user_length);
          end
          if (got.has_integrity !== want.has_integrity) begin
            errors++;
            $display("%0t: has_integrity exp %h got %h", $time, want.has_integrity,
                     got.has_integrity);
          end
          if (got.fp_seen !== want.fp_seen) begin
            errors++;
            $display("%0t: fp_seen exp %h got %h", $time, want.fp_seen, got.fp_seen);
          end
          if (got.fingerprint_ok !== want.fingerprint_ok) begin
            errors++;
            $display("%0t: fingerprint_ok exp %h got %h", $time, want.fingerprint_ok,
                     got.fingerprint_ok);
          end
          if (got.txid_high !== want.txid_high) begin
            errors++;
            $display("%0t: txid_high exp %h got %h", $time, want.txid_high, got.txid_high);
          end
          if (got.txid_low !== want.txid_low) begin
            errors++;
            $display("%0t: txid_low exp %h got %h", $time, want.txid_low, got.txid_low);
          end
          if (got.last !== want.last) begin
            errors++;
            $display("%0t: last exp %h got %h", $time, want.last, got.last);
          end
        end
      end
      out_stall <= idle_free ? 1'b0 : ($urandom_range(0, 99) < 36);
    end
  end

  int total_bytes;
  initial begin
    clear_packet_model();
    idle_free = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // Directed packets: good ones, error kinds of shapes 3 to 8, short and long usernames.
    build_packet(0, 1); queue_packet();
    build_packet(1, 255); queue_packet();
    build_packet(0, 300); queue_packet();
    build_packet(3, 4); queue_packet();
    build_packet(4, 5); queue_packet();
    build_packet(5, 3); queue_packet();
    build_packet(6, 6); queue_packet();
    build_packet(7, 2); queue_packet();
    build_packet(8, 8); queue_packet();
    build_packet(0, 0); queue_packet();
    pkt.delete();
    for (int i = 0; i < 12; i++) pkt.push_back(8'(8'hff - i));
    queue_packet();
    pkt.delete(); pkt.push_back(8'hff); queue_packet();
    pkt.delete(); pkt.push_back(8'h00); queue_packet();
    total_bytes = 0;
    foreach (pending_bytes[i]) total_bytes++;
    while (total_bytes < 1750) begin
      build_packet($urandom_range(0, 3) == 0 ? $urandom_range(3, 9) : $urandom_range(0, 2),
                   $urandom_range(0, 15) == 0 ? $urandom_range(200, 300) : $urandom_range(1, 24));
      queue_packet();
      total_bytes += pkt.size();
      if (total_bytes > 700 && total_bytes < 1000) idle_free = 1;
      else idle_free = 0;
      while (pending_bytes.size() > 200) @(posedge clk);
    end
    idle_free = 0;
    while (pending_bytes.size() > 0) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d packets (%0d bytes), checked %0d result items.", packets_sent,
             total_bytes, results_seen);
    if (errors == 0) begin
      $display("tb_stun_binding_request_parser_core passed");
    end else begin
      $display("tb_stun_binding_request_parser_core failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d result items outstanding.", expected_results.size());
    $display("tb_stun_binding_request_parser_core failed");
    $finish;
  end

endmodule

`default_nettype wire
